[src/hbfl_pkg.sv]
package hbfl_pkg;

    localparam logic [7:0] FPS_TRUST = 8'd4;

    localparam logic CFG_HEAT_LIMIT   = 1'b0;
    localparam logic CFG_COOLING_RATE = 1'b1;

    localparam logic signed [27:0] MILLI_PER_HEAT = 28'sd1000;
    localparam logic signed [30:0] MILLI_PER_SHOT = 31'sd10000;
    localparam logic [25:0]        CEIL_SCALE     = 26'd1000;

    // floor(x / 10) = (x * 52429) >> 19, exact for x below 2^18
    localparam logic [31:0] RECIP_10   = 32'd52429;
    // floor(x / 625) = (x * 6871948) >> 32, exact for x below 2^24
    localparam logic [44:0] RECIP_625  = 45'd6871948;

    localparam logic signed [15:0] ALLOWED_MIN = 16'sh8000;

    typedef struct packed {
        logic                healthy;
        logic [15:0]         heat;
        logic [15:0]         speed;
        logic [15:0]         shots;
        logic [31:0]         time_ms;
        logic                wheels_ok;
        logic signed [27:0]  hr_milli;
        logic signed [13:0]  hr_div10;
        logic [43:0]         cool_gain;
        logic signed [30:0]  shot_cost;
    } t_item;

    typedef struct packed {
        logic [15:0]         prev_heat;
        logic [15:0]         prev_speed;
        logic [31:0]         last_time;
        logic signed [27:0]  budget;
        logic signed [15:0]  allowed;
        logic [15:0]         prev_shots;
    } t_state;

    // signed divide by ten, truncating toward zero
    function automatic logic signed [13:0] div10_trunc(input logic signed [16:0] v);
        logic [15:0] mag;
        logic [31:0] prod;
        logic [12:0] q;
        mag  = v[16] ? 16'(-v) : v[15:0];
        prod = 32'(mag) * RECIP_10;
        q    = prod[31:19];
        return v[16] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // unsigned divide by 10000 for values below 2^26
    function automatic logic [12:0] div10000(input logic [25:0] v);
        logic [44:0] prod;
        prod = 45'(v[25:4]) * RECIP_625;
        return prod[44:32];
    endfunction

endpackage

[src/hbfl_prep.sv]
module hbfl_prep (
    input  logic [7:0]          i_referee_fps,
    input  logic [15:0]         i_heat_reported,
    input  logic [15:0]         i_speed_reported,
    input  logic [15:0]         i_shots_fired,
    input  logic [31:0]         i_time_ms,
    input  logic [15:0]         i_left_wheel_fps,
    input  logic [15:0]         i_right_wheel_fps,
    input  logic [15:0]         i_heat_limit,
    input  logic [11:0]         i_cooling_rate,
    input  logic [31:0]         i_last_time,
    input  logic [15:0]         i_prev_shots,
    output hbfl_pkg::t_item     o_item
);
    import hbfl_pkg::*;

    logic signed [16:0] headroom;
    logic signed [16:0] delta;
    logic [31:0]        elapsed;

    always_comb begin
        headroom = $signed({1'b0, i_heat_limit}) - $signed({1'b0, i_heat_reported});
        delta    = $signed({1'b0, i_shots_fired}) - $signed({1'b0, i_prev_shots});
        elapsed  = i_time_ms - i_last_time;

        o_item.healthy   = i_referee_fps > FPS_TRUST;
        o_item.heat      = i_heat_reported;
        o_item.speed     = i_speed_reported;
        o_item.shots     = i_shots_fired;
        o_item.time_ms   = i_time_ms;
        o_item.wheels_ok = (i_left_wheel_fps != 16'd0) && (i_right_wheel_fps != 16'd0);
        o_item.hr_milli  = $signed({{11{headroom[16]}}, headroom}) * MILLI_PER_HEAT;
        o_item.hr_div10  = div10_trunc(headroom);
        o_item.cool_gain = 44'(i_cooling_rate) * 44'(elapsed);
        o_item.shot_cost = $signed({{14{delta[16]}}, delta}) * MILLI_PER_SHOT;
    end

endmodule

[src/hbfl_update.sv]
module hbfl_update (
    input  hbfl_pkg::t_item     i_item,
    input  hbfl_pkg::t_state    i_state,
    input  logic [25:0]         i_ceil,
    output hbfl_pkg::t_state    o_state,
    output logic                o_fire
);
    import hbfl_pkg::*;

    logic signed [45:0] sum;
    logic [25:0]        clamped;
    logic signed [15:0] dec;
    logic               spd_chg;
    logic               heat_chg;

    always_comb begin
        sum = $signed({{18{i_state.budget[27]}}, i_state.budget})
            - $signed({{15{i_item.shot_cost[30]}}, i_item.shot_cost})
            + $signed({2'b00, i_item.cool_gain});

        if (sum[45]) begin
            clamped = 26'd0;
        end else if (sum > $signed({20'd0, i_ceil})) begin
            clamped = i_ceil;
        end else begin
            clamped = sum[25:0];
        end

        dec      = (i_state.allowed == ALLOWED_MIN) ? i_state.allowed
                                                    : i_state.allowed - 16'sd1;
        spd_chg  = i_item.speed != i_state.prev_speed;
        heat_chg = (i_item.heat != i_state.prev_heat) || (i_item.heat == 16'd0);

        o_state = i_state;
        if (i_item.healthy) begin
            if (spd_chg) begin
                o_state.allowed = dec;
            end else if (heat_chg) begin
                o_state.allowed = 16'($signed(i_item.hr_div10));
            end
            o_state.prev_heat  = i_item.heat;
            o_state.prev_speed = i_item.speed;
            o_state.budget     = i_item.hr_milli;
        end else begin
            o_state.budget     = $signed({2'b00, clamped});
            o_state.allowed    = $signed({3'b000, div10000(clamped)});
            o_state.last_time  = i_item.time_ms;
            o_state.prev_shots = i_item.shots;
        end

        o_fire = ($signed(o_state.allowed) > 16'sd1) && i_item.wheels_ok;
    end

endmodule

[src/heat_budget_fire_limiter.sv]
// Heat budget fire limiter.
// Input channel (i_in_valid / o_in_stall) carries one control tick per
// request: referee link rate, reported heat and speed, feeder shot count,
// time in ms and both wheel link rates. Output channel (o_out_valid /
// i_out_stall) returns one result per request: fire permission, shots still
// allowed and remaining heat budget in milli-heat.
// The block takes one request per cycle while the receiver does not stall.
// The input register holds the request with headroom, cooling gain and shot
// cost worked out; the update then changes the budget state and loads the
// result register.
// While the receiver stalls, the result holds and one more request may wait
// in the input register; o_in_stall rises once both are full.
// The config port writes heat_limit (index 0) and cooling_rate (index 1),
// only while no request is in flight: a rule for the user, not enforced by
// the block. Reset clears both registers, budget state and pipeline.
module heat_budget_fire_limiter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_referee_fps,
    input  logic [15:0]         i_heat_reported,
    input  logic [15:0]         i_speed_reported,
    input  logic [15:0]         i_shots_fired,
    input  logic [31:0]         i_time_ms,
    input  logic [15:0]         i_left_wheel_fps,
    input  logic [15:0]         i_right_wheel_fps,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_fire_allowed,
    output logic signed [15:0]  o_shots_allowed,
    output logic signed [26:0]  o_heat_left_milli
);
    import hbfl_pkg::*;

    logic [15:0]        r_heat_limit;
    logic [11:0]        r_cooling_rate;
    logic [25:0]        r_ceil;
    t_item              r_a;
    logic               r_a_valid;
    t_state             r_st;
    logic               r_out_valid;
    logic               r_fire;
    logic signed [15:0] r_shots;
    logic signed [26:0] r_budget_milli;

    t_item              n_a;
    t_state             n_st;
    logic               n_fire;
    logic               a_move;
    logic               in_take;
    logic [31:0]        fwd_last_time;
    logic [15:0]        fwd_prev_shots;

    assign a_move     = r_a_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_move;
    assign in_take    = i_in_valid && !o_in_stall;

    // state as the request in the input register will leave it
    assign fwd_last_time  = (r_a_valid && !r_a.healthy) ? r_a.time_ms : r_st.last_time;
    assign fwd_prev_shots = (r_a_valid && !r_a.healthy) ? r_a.shots   : r_st.prev_shots;

    hbfl_prep u_prep (
        .i_referee_fps     (i_referee_fps),
        .i_heat_reported   (i_heat_reported),
        .i_speed_reported  (i_speed_reported),
        .i_shots_fired     (i_shots_fired),
        .i_time_ms         (i_time_ms),
        .i_left_wheel_fps  (i_left_wheel_fps),
        .i_right_wheel_fps (i_right_wheel_fps),
        .i_heat_limit      (r_heat_limit),
        .i_cooling_rate    (r_cooling_rate),
        .i_last_time       (fwd_last_time),
        .i_prev_shots      (fwd_prev_shots),
        .o_item            (n_a)
    );

    hbfl_update u_update (
        .i_item  (r_a),
        .i_state (r_st),
        .i_ceil  (r_ceil),
        .o_state (n_st),
        .o_fire  (n_fire)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_limit   <= 16'd0;
            r_cooling_rate <= 12'd0;
            r_ceil         <= 26'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEAT_LIMIT: begin
                    r_heat_limit <= i_cfg_wdata;
                    r_ceil       <= 26'(i_cfg_wdata) * CEIL_SCALE;
                end
                CFG_COOLING_RATE: begin
                    r_cooling_rate <= i_cfg_wdata[11:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (in_take) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a <= n_a;
        end
        if (a_move) begin
            r_fire         <= n_fire;
            r_shots        <= n_st.allowed;
            r_budget_milli <= n_st.budget[26:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fire_allowed    = r_fire;
    assign o_shots_allowed   = r_shots;
    assign o_heat_left_milli = r_budget_milli;

    a_fire_needs_shots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fire_allowed |-> $signed(o_shots_allowed) > 16'sd1)
        else $error("fire allowed with too few shots");

    a_estimate_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move && !r_a.healthy && !i_cfg_we |=>
            !r_st.budget[27] && (r_st.budget <= $signed({2'b00, r_ceil})))
        else $error("local heat estimate outside clamp range");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_a_valid))
        else $error("result without a request in the input register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_a_valid)
        else $error("pipeline not empty after reset");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import hbfl_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0]  fps;
        logic [15:0] heat;
        logic [15:0] speed;
        logic [15:0] shots;
        logic [31:0] time_ms;
        logic [15:0] lwf;
        logic [15:0] rwf;
    } t_tick;

    typedef struct packed {
        logic               fire;
        logic signed [15:0] shots_left;
        logic        [26:0] budget_milli;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_referee_fps = '0;
    logic [15:0]        i_heat_reported = '0;
    logic [15:0]        i_speed_reported = '0;
    logic [15:0]        i_shots_fired = '0;
    logic [31:0]        i_time_ms = '0;
    logic [15:0]        i_left_wheel_fps = '0;
    logic [15:0]        i_right_wheel_fps = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_fire_allowed;
    logic signed [15:0] o_shots_allowed;
    logic signed [26:0] o_heat_left_milli;

    heat_budget_fire_limiter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_referee_fps     (i_referee_fps),
        .i_heat_reported   (i_heat_reported),
        .i_speed_reported  (i_speed_reported),
        .i_shots_fired     (i_shots_fired),
        .i_time_ms         (i_time_ms),
        .i_left_wheel_fps  (i_left_wheel_fps),
        .i_right_wheel_fps (i_right_wheel_fps),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_fire_allowed    (o_fire_allowed),
        .o_shots_allowed   (o_shots_allowed),
        .o_heat_left_milli (o_heat_left_milli)
    );

    always #5 i_clk = ~i_clk;

    // budget model state and its copy of the registers
    logic [15:0]        cfg_limit;
    logic [11:0]        cfg_cool;
    logic [15:0]        m_prev_heat;
    logic [15:0]        m_prev_speed;
    logic [15:0]        m_prev_shots;
    logic [31:0]        m_last_time;
    logic signed [27:0] m_budget;
    logic signed [15:0] m_allowed;

    t_verdict expected_verdicts[$];
    int       err_count = 0;
    int       snd_idle_pct = 0;
    int       rcv_stall_pct = 0;
    int       hold_requests = 0;

    // random request generator state
    logic        s_link_good = 1'b1;
    logic [15:0] s_heat = '0;
    logic [15:0] s_speed = '0;
    logic [15:0] s_shots = '0;
    logic [31:0] s_time = '0;

    function automatic void clear_budget_model();
        cfg_limit    = '0;
        cfg_cool     = '0;
        m_prev_heat  = '0;
        m_prev_speed = '0;
        m_prev_shots = '0;
        m_last_time  = '0;
        m_budget     = '0;
        m_allowed    = '0;
    endfunction

    function automatic t_verdict budget_predict(input t_tick t);
        t_verdict   v;
        int         headroom;
        longint     delta;
        longint     b;
        longint     ceiling;
        logic [31:0] elapsed;
        if (t.fps > FPS_TRUST) begin
            headroom = int'(cfg_limit) - int'(t.heat);
            if (t.speed != m_prev_speed) begin
                if (m_allowed != ALLOWED_MIN)
                    m_allowed = m_allowed - 16'sd1;
            end else if (t.heat != m_prev_heat || t.heat == 16'd0) begin
                m_allowed = 16'(headroom / 10);
            end
            m_prev_heat  = t.heat;
            m_prev_speed = t.speed;
            m_budget     = 28'(headroom * 1000);
        end else begin
            delta   = longint'(t.shots) - longint'(m_prev_shots);
            elapsed = t.time_ms - m_last_time;
            ceiling = longint'(cfg_limit) * 1000;
            b = longint'(m_budget) - delta * 10000 + longint'(cfg_cool) * longint'(elapsed);
            if (b > ceiling)
                b = ceiling;
            if (b < 0)
                b = 0;
            m_budget     = 28'(b);
            m_allowed    = 16'(b / 10000);
            m_last_time  = t.time_ms;
            m_prev_shots = t.shots;
        end
        v.fire         = (m_allowed > 16'sd1) && (t.lwf != 16'd0) && (t.rwf != 16'd0);
        v.shots_left   = m_allowed;
        v.budget_milli = m_budget[26:0];
        return v;
    endfunction

    function automatic t_tick mk_tick(input logic [7:0] fps, input logic [15:0] heat,
                                      input logic [15:0] speed, input logic [15:0] shots,
                                      input logic [31:0] tms, input logic [15:0] lwf,
                                      input logic [15:0] rwf);
        t_tick t;
        t.fps     = fps;
        t.heat    = heat;
        t.speed   = speed;
        t.shots   = shots;
        t.time_ms = tms;
        t.lwf     = lwf;
        t.rwf     = rwf;
        return t;
    endfunction

    function automatic logic [15:0] wheel_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'd0;
        else if (r < 16)
            return 16'($urandom);
        return 16'($urandom_range(1, 2000));
    endfunction

    // mostly plausible referee/feeder traffic, with some raw noise
    function automatic t_tick random_tick();
        t_tick t;
        int    r;
        if ($urandom_range(0, 99) < 6)
            s_link_good = !s_link_good;
        r = $urandom_range(0, 99);
        if (r < 5)
            t.fps = 8'($urandom);
        else if (r < 15)
            t.fps = s_link_good ? 8'd5 : 8'd4;
        else
            t.fps = s_link_good ? 8'($urandom_range(5, 255)) : 8'($urandom_range(0, 4));
        r = $urandom_range(0, 99);
        if (r >= 55 && r < 70)
            s_heat = 16'($urandom_range(0, int'(cfg_limit)));
        else if (r >= 70 && r < 78)
            s_heat = 16'(int'(cfg_limit) + $urandom_range(0, 30) - 15);
        else if (r >= 78 && r < 88)
            s_heat = '0;
        else if (r >= 88)
            s_heat = 16'($urandom);
        if ($urandom_range(0, 99) < 20)
            s_speed = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r >= 55 && r < 85)
            s_shots = s_shots + 16'($urandom_range(1, 3));
        else if (r >= 85 && r < 92)
            s_shots = '0;
        else if (r >= 92)
            s_shots = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 85)
            s_time = s_time + 32'($urandom_range(0, 20));
        else if (r < 95)
            s_time = s_time + 32'($urandom_range(0, 200000));
        else
            s_time = $urandom;
        t.heat    = s_heat;
        t.speed   = s_speed;
        t.shots   = s_shots;
        t.time_ms = s_time;
        t.lwf     = wheel_rate();
        t.rwf     = wheel_rate();
        return t;
    endfunction

    task automatic send_tick(input t_tick t);
        i_in_valid        <= 1'b1;
        i_referee_fps     <= t.fps;
        i_heat_reported   <= t.heat;
        i_speed_reported  <= t.speed;
        i_shots_fired     <= t.shots;
        i_time_ms         <= t.time_ms;
        i_left_wheel_fps  <= t.lwf;
        i_right_wheel_fps <= t.rwf;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_verdicts.push_back(budget_predict(t));
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [15:0] limit, input logic [11:0] cool);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_HEAT_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_COOLING_RATE;
        i_cfg_wdata <= {4'd0, cool};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_limit = limit;
        cfg_cool  = cool;
    endtask

    task automatic run_reset();
        clear_budget_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        load_limits(16'hFFFF, 12'hFFF);
        // zero heat reload, changed heat, unchanged heat, speed change
        send_tick(mk_tick(8'd255, 16'd0, 16'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_tick(mk_tick(8'd5, 16'd100, 16'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_tick(mk_tick(8'd5, 16'd100, 16'd0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_tick(mk_tick(8'd5, 16'd100, 16'd7, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF));
        send_tick(mk_tick(8'd5, 16'hFFFF, 16'd7, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF));
        // local estimate: cooling, huge shot delta, counter drop, time wrap
        send_tick(mk_tick(8'd4, 16'd0, 16'd0, 16'd3, 32'd1000, 16'hFFFF, 16'hFFFF));
        send_tick(mk_tick(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0, 16'd9, 16'd9));
        send_tick(mk_tick(8'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0010, 16'd9, 16'd9));
        send_tick(mk_tick(8'd1, 16'd0, 16'd0, 16'hFFFF, 32'h0000_0010, 16'd9, 16'd9));
        // dead wheel links
        send_tick(mk_tick(8'd200, 16'd1000, 16'd7, 16'd0, 32'd0, 16'd0, 16'hFFFF));
        send_tick(mk_tick(8'd200, 16'd1000, 16'd7, 16'd0, 32'd0, 16'hFFFF, 16'd0));
        send_tick(mk_tick(8'd200, 16'd1000, 16'd7, 16'd0, 32'd0, 16'd1, 16'd1));
        // heat above the limit: negative headroom, then clamp to zero
        load_limits(16'd0, 12'd0);
        send_tick(mk_tick(8'd5, 16'hFFFF, 16'd7, 16'd0, 32'd0, 16'd1, 16'd1));
        send_tick(mk_tick(8'd4, 16'd0, 16'd0, 16'hFFFF, 32'h0000_0011, 16'd1, 16'd1));
        // fire threshold between one and two shots left
        load_limits(16'd25, 12'd0);
        send_tick(mk_tick(8'd0, 16'd0, 16'd0, 16'hFFFD, 32'h0000_0012, 16'd1, 16'd1));
        send_tick(mk_tick(8'd0, 16'd0, 16'd0, 16'hFFFE, 32'h0000_0013, 16'd1, 16'd1));
        send_tick(mk_tick(8'd0, 16'd0, 16'd0, 16'hFFFC, 32'h0000_0014, 16'd1, 16'd1));
    endtask

    task automatic test_speed_run();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        load_limits(16'd0, 12'd0);
        send_tick(mk_tick(8'd255, 16'hFFFF, 16'd0, 16'd0, 32'd0, 16'd1, 16'd1));
        send_tick(mk_tick(8'd255, 16'hFFFE, 16'd0, 16'd0, 32'd0, 16'd1, 16'd1));
        // every request changes speed, counting down from a negative reload
        for (int i = 1; i <= 20; i++)
            send_tick(mk_tick(8'd255, 16'hFFFE, 16'(i), 16'd0, 32'd0, 16'd1, 16'd1));
    endtask

    task automatic run_random_phase(input int snd, input int rcv, input int n);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        for (int i = 0; i < n; i++)
            send_tick(random_tick());
    endtask

    task automatic test_random();
        load_limits(16'($urandom), 12'($urandom));
        run_random_phase(0, 0, 200);
        load_limits(16'hFFFF, 12'hFFF);
        run_random_phase(87, 0, 200);
        load_limits(16'd300, 12'd50);
        run_random_phase(0, 87, 200);
        load_limits(16'($urandom_range(0, 2000)), 12'($urandom));
        run_random_phase(17, 17, 200);
    endtask

    task automatic test_backpressure();
        load_limits(16'd500, 12'd200);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_requests++;
        for (int i = 0; i < 30; i++)
            send_tick(random_tick());
    endtask

    // receiver: random stalls, plus long hold-offs on demand
    int holds_served = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                err_count++;
                $display("%0t: result with no request pending", $time);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_fire_allowed !== want.fire) begin
                    err_count++;
                    $display("%0t: fire_allowed exp %0d got %0d",
                             $time, want.fire, o_fire_allowed);
                end
                if (o_shots_allowed !== want.shots_left) begin
                    err_count++;
                    $display("%0t: shots_allowed exp %0d got %0d",
                             $time, want.shots_left, o_shots_allowed);
                end
                if (o_heat_left_milli !== want.budget_milli) begin
                    err_count++;
                    $display("%0t: heat_left_milli exp %0d got %0d",
                             $time, $signed(want.budget_milli), o_heat_left_milli);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                    || (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        run_reset();
        test_directed();
        test_speed_run();
        test_random();
        test_backpressure();
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
